// ===== hdl/pgn_pkg.sv =====
package pgn_pkg;

  localparam int FRAC_BITS = 16;
  localparam int POS_W     = 24;
  localparam int GRAD_W    = 16;
  localparam int PERM_W    = 8;
  localparam int OUT_W     = 16;
  localparam int CFG_W     = 4;

  // Smoothed weights run from 0 to one inclusive, so they need one bit above the fraction.
  localparam int WGT_W    = FRAC_BITS + 1;
  localparam int PROD_W   = GRAD_W + FRAC_BITS + 1;
  localparam int DSUM_W   = PROD_W + 2;
  localparam int DOT_W    = DSUM_W - FRAC_BITS;
  localparam int TERM_W   = DOT_W + WGT_W + 1;
  localparam int OSUM_W   = TERM_W + 3;

  localparam logic [FRAC_BITS+1:0] THREE_ONE = {2'b11, {FRAC_BITS{1'b0}}};
  localparam logic [WGT_W-1:0]     WGT_ONE   = {1'b1, {FRAC_BITS{1'b0}}};

  localparam logic [2:0] KIND_GRAD   = 3'd0;
  localparam logic [2:0] KIND_PERM_X = 3'd1;
  localparam logic [2:0] KIND_PERM_Y = 3'd2;
  localparam logic [2:0] KIND_PERM_Z = 3'd3;
  localparam logic [2:0] KIND_EVAL   = 3'd4;

  localparam logic REG_OCTAVE_COUNT = 1'b0;
  localparam logic REG_TURB_MODE    = 1'b1;

  typedef struct packed {
    logic [WGT_W-1:0] lo;
    logic [WGT_W-1:0] hi;
  } wpair_t;

  typedef struct packed {
    logic valid;
    logic a;
    logic b;
    logic c;
    logic last;
  } corner_tag_t;

endpackage

// ===== hdl/perlin_gradient_noise_turbulence.sv =====
// A load transaction writes its table entry as it is accepted and leaves the block ready.
// An evaluate transaction runs, per octave: setup, six permutation reads and a capture, eight
// gradient reads through the shared corner pipeline and its drain. Its result becomes valid as
// the block turns ready for the next transaction; the finish waits while an earlier result is unread.
// Reset clears control state and sets octave_count to 7 and turbulence_mode to 1;
// the tables are not cleared and must be loaded before use.
module perlin_gradient_noise_turbulence import pgn_pkg::*; #(
  parameter int TABLE_SIZE  = 256,
  parameter int MAX_OCTAVES = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               kind_i,
  input  logic [7:0]               table_index_i,
  input  logic [PERM_W-1:0]        perm_value_i,
  input  logic signed [GRAD_W-1:0] grad_x_i,
  input  logic signed [GRAD_W-1:0] grad_y_i,
  input  logic signed [GRAD_W-1:0] grad_z_i,
  input  logic signed [POS_W-1:0]  pos_x_i,
  input  logic signed [POS_W-1:0]  pos_y_i,
  input  logic signed [POS_W-1:0]  pos_z_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [OUT_W-1:0]  noise_value_o
);

  localparam int IW     = $clog2(TABLE_SIZE);
  localparam int OCW    = $clog2(MAX_OCTAVES + 1);
  localparam int ACC_W  = OSUM_W + OCW;
  localparam int RES_W  = ACC_W - FRAC_BITS;
  localparam int SH_W   = 48;
  localparam logic [4:0] MAX_OCT5 = 5'(MAX_OCTAVES);
  localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(32767);
  localparam logic signed [RES_W-1:0] SAT_LO = -RES_W'(32768);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SETUP  = 6'b000010,
    ST_PERM   = 6'b000100,
    ST_CORNER = 6'b001000,
    ST_WAIT   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0]        octave_count_q;
  logic                    turb_q;
  logic [OCW-1:0]          oct_q, n_q, n_d;
  logic [4:0]              oc_ext, n_wide;
  logic [2:0]              step_q;
  logic signed [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic [SH_W-1:0]         shx, shy, shz;
  logic [IW-1:0]           cell_x_q, cell_y_q, cell_z_q;
  logic [FRAC_BITS-1:0]    frac_x_q, frac_y_q, frac_z_q;
  logic [PERM_W-1:0]       px0_q, px1_q, py0_q, py1_q, pz0_q, pz1_q;
  logic [PERM_W-1:0]       hash;
  logic [IW+PERM_W-1:0]    hash_ext, tidx_ext;
  logic signed [ACC_W-1:0] acc_q, oct_term;
  logic signed [RES_W-1:0] res, res_abs, res_sat;
  logic signed [OUT_W-1:0] noise_q;
  logic                    out_valid_q;

  logic                    in_acc;
  logic [IW-1:0]           waddr;
  logic [2:0]              perm_we;
  logic                    grad_we;
  logic [IW-1:0]           perm_raddr, grad_raddr;
  logic [3*PERM_W-1:0]     perm_rdata;
  logic [3*GRAD_W-1:0]     grad_rdata;
  corner_tag_t             tag;
  wpair_t                  wx, wy, wz;
  logic signed [OSUM_W-1:0] osum;
  logic                    corner_done;
  logic                    finish_go;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octave_count_q <= CFG_W'(7);
      turb_q         <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_OCTAVE_COUNT) octave_count_q <= cfg_wdata_i;
      if (cfg_index_i == REG_TURB_MODE)    turb_q <= cfg_wdata_i[0];
    end
  end

  // Table loads.
  assign tidx_ext = {{IW{1'b0}}, table_index_i};
  assign waddr    = tidx_ext[IW-1:0];
  assign grad_we  = in_acc && (kind_i == KIND_GRAD);
  assign perm_we  = {in_acc && (kind_i == KIND_PERM_Z),
                     in_acc && (kind_i == KIND_PERM_Y),
                     in_acc && (kind_i == KIND_PERM_X)};

  assign oc_ext = {1'b0, octave_count_q};
  assign n_wide = turb_q ? ((oc_ext > MAX_OCT5) ? MAX_OCT5 : oc_ext) : 5'd1;
  assign n_d    = n_wide[OCW-1:0];

  // The point doubles each octave; the integer part keeps wrapping with the table.
  assign shx = SH_W'(pos_x_q) << oct_q;
  assign shy = SH_W'(pos_y_q) << oct_q;
  assign shz = SH_W'(pos_z_q) << oct_q;

  always_comb begin
    case (step_q)
      3'd0:    perm_raddr = cell_x_q;
      3'd1:    perm_raddr = cell_x_q + IW'(1);
      3'd2:    perm_raddr = cell_y_q;
      3'd3:    perm_raddr = cell_y_q + IW'(1);
      3'd4:    perm_raddr = cell_z_q;
      default: perm_raddr = cell_z_q + IW'(1);
    endcase
  end

  assign hash = (step_q[2] ? px1_q : px0_q) ^ (step_q[1] ? py1_q : py0_q)
              ^ (step_q[0] ? pz1_q : pz0_q);
  assign hash_ext   = {{IW{1'b0}}, hash};
  assign grad_raddr = hash_ext[IW-1:0];

  assign tag.valid = (state_q == ST_CORNER);
  assign tag.a     = step_q[2];
  assign tag.b     = step_q[1];
  assign tag.c     = step_q[0];
  assign tag.last  = (step_q == 3'd7);

  assign oct_term = $signed(ACC_W'(osum)) >>> oct_q;

  assign res     = acc_q[ACC_W-1:FRAC_BITS];
  assign res_abs = (turb_q && res < 0) ? -res : res;
  assign res_sat = (res_abs > SAT_HI) ? SAT_HI : ((res_abs < SAT_LO) ? SAT_LO : res_abs);

  assign finish_go = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && kind_i == KIND_EVAL) begin
          state_d = (n_d == '0) ? ST_FINISH : ST_SETUP;
        end
      end
      ST_SETUP:  state_d = ST_PERM;
      ST_PERM: begin
        if (step_q == 3'd6) state_d = ST_CORNER;
      end
      ST_CORNER: begin
        if (step_q == 3'd7) state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (corner_done) begin
          state_d = (oct_q + OCW'(1) == n_q) ? ST_FINISH : ST_SETUP;
        end
      end
      ST_FINISH: begin
        if (finish_go) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      oct_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_PERM || state_q == ST_CORNER) begin
        step_q <= (state_d == state_q) ? step_q + 3'd1 : 3'd0;
      end else begin
        step_q <= '0;
      end
      if (in_acc) begin
        oct_q <= '0;
        n_q   <= n_d;
      end else if (state_q == ST_WAIT && corner_done) begin
        oct_q <= oct_q + OCW'(1);
      end
      if (finish_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pos_x_q <= pos_x_i;
      pos_y_q <= pos_y_i;
      pos_z_q <= pos_z_i;
      acc_q   <= '0;
    end else if (state_q == ST_WAIT && corner_done) begin
      acc_q <= acc_q + oct_term;
    end
    if (state_q == ST_SETUP) begin
      cell_x_q <= shx[FRAC_BITS +: IW];
      cell_y_q <= shy[FRAC_BITS +: IW];
      cell_z_q <= shz[FRAC_BITS +: IW];
      frac_x_q <= shx[FRAC_BITS-1:0];
      frac_y_q <= shy[FRAC_BITS-1:0];
      frac_z_q <= shz[FRAC_BITS-1:0];
    end
    // Read data trails its address by the table's read register.
    if (state_q == ST_PERM) begin
      case (step_q)
        3'd1:    px0_q <= perm_rdata[PERM_W-1:0];
        3'd2:    px1_q <= perm_rdata[PERM_W-1:0];
        3'd3:    py0_q <= perm_rdata[2*PERM_W-1:PERM_W];
        3'd4:    py1_q <= perm_rdata[2*PERM_W-1:PERM_W];
        3'd5:    pz0_q <= perm_rdata[3*PERM_W-1:2*PERM_W];
        3'd6:    pz1_q <= perm_rdata[3*PERM_W-1:2*PERM_W];
        default: ;
      endcase
    end
    if (finish_go) noise_q <= res_sat[OUT_W-1:0];
  end

  pgn_tables #(
    .TABLE_SIZE (TABLE_SIZE),
    .IW         (IW)
  ) u_tables (
    .clk_i        (clk_i),
    .waddr_i      (waddr),
    .perm_we_i    (perm_we),
    .perm_wdata_i (perm_value_i),
    .grad_we_i    (grad_we),
    .grad_wdata_i ({grad_x_i, grad_y_i, grad_z_i}),
    .perm_raddr_i (perm_raddr),
    .perm_rdata_o (perm_rdata),
    .grad_raddr_i (grad_raddr),
    .grad_rdata_o (grad_rdata)
  );

  pgn_smooth u_smooth_x (.clk_i(clk_i), .frac_i(frac_x_q), .wgt_o(wx));
  pgn_smooth u_smooth_y (.clk_i(clk_i), .frac_i(frac_y_q), .wgt_o(wy));
  pgn_smooth u_smooth_z (.clk_i(clk_i), .frac_i(frac_z_q), .wgt_o(wz));

  pgn_corner u_corner (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (state_q == ST_SETUP),
    .tag_i    (tag),
    .grad_i   (grad_rdata),
    .frac_x_i (frac_x_q),
    .frac_y_i (frac_y_q),
    .frac_z_i (frac_z_q),
    .wx_i     (wx),
    .wy_i     (wy),
    .wz_i     (wz),
    .osum_o   (osum),
    .done_o   (corner_done)
  );

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = noise_q;

`ifndef ASSERT_OFF
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    corner_done |-> state_q == ST_WAIT)
    else $error("corner sum finished outside the wait state");

  a_octave_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SETUP |-> oct_q < n_q)
    else $error("octave index ran past the octave count");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result appeared without a finished evaluation");
`endif

endmodule

// ===== hdl/pgn_tables.sv =====
module pgn_tables import pgn_pkg::*; #(
  parameter int TABLE_SIZE = 256,
  parameter int IW         = 8
) (
  input  logic                  clk_i,
  input  logic [IW-1:0]         waddr_i,
  input  logic [2:0]            perm_we_i,
  input  logic [PERM_W-1:0]     perm_wdata_i,
  input  logic                  grad_we_i,
  input  logic [3*GRAD_W-1:0]   grad_wdata_i,
  input  logic [IW-1:0]         perm_raddr_i,
  output logic [3*PERM_W-1:0]   perm_rdata_o,
  input  logic [IW-1:0]         grad_raddr_i,
  output logic [3*GRAD_W-1:0]   grad_rdata_o
);

  // Permutation memory holds the x, y and z tables as byte lanes of one word.
  logic [3*PERM_W-1:0] perm_mem [TABLE_SIZE];
  logic [3*GRAD_W-1:0] grad_mem [TABLE_SIZE];

  always_ff @(posedge clk_i) begin
    if (perm_we_i[0]) perm_mem[waddr_i][PERM_W-1:0] <= perm_wdata_i;
    if (perm_we_i[1]) perm_mem[waddr_i][2*PERM_W-1:PERM_W] <= perm_wdata_i;
    if (perm_we_i[2]) perm_mem[waddr_i][3*PERM_W-1:2*PERM_W] <= perm_wdata_i;
    perm_rdata_o <= perm_mem[perm_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (grad_we_i) grad_mem[waddr_i] <= grad_wdata_i;
    grad_rdata_o <= grad_mem[grad_raddr_i];
  end

endmodule

// ===== hdl/pgn_smooth.sv =====
module pgn_smooth import pgn_pkg::*; (
  input  logic                 clk_i,
  input  logic [FRAC_BITS-1:0] frac_i,
  output wpair_t               wgt_o
);

  logic [2*FRAC_BITS-1:0] sq;
  logic [FRAC_BITS-1:0]   f2_q;
  logic [FRAC_BITS+1:0]   t_q;
  logic [2*FRAC_BITS+1:0] prod;
  logic [WGT_W-1:0]       s_q;

  assign sq   = frac_i * frac_i;
  assign prod = f2_q * t_q;

  // Hermite weight f*f*(3-2f), floored after each product.
  always_ff @(posedge clk_i) begin
    f2_q <= sq[2*FRAC_BITS-1:FRAC_BITS];
    t_q  <= THREE_ONE - {1'b0, frac_i, 1'b0};
    s_q  <= prod[FRAC_BITS +: WGT_W];
  end

  assign wgt_o.hi = s_q;
  assign wgt_o.lo = WGT_ONE - s_q;

endmodule

// ===== hdl/pgn_corner.sv =====
module pgn_corner import pgn_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  corner_tag_t               tag_i,
  input  logic [3*GRAD_W-1:0]       grad_i,
  input  logic [FRAC_BITS-1:0]      frac_x_i,
  input  logic [FRAC_BITS-1:0]      frac_y_i,
  input  logic [FRAC_BITS-1:0]      frac_z_i,
  input  wpair_t                    wx_i,
  input  wpair_t                    wy_i,
  input  wpair_t                    wz_i,
  output logic signed [OSUM_W-1:0]  osum_o,
  output logic                      done_o
);

  corner_tag_t t1_q, t2_q, t3_q, t4_q;

  logic signed [GRAD_W-1:0]    gx, gy, gz;
  logic signed [FRAC_BITS:0]   offx, offy, offz;
  logic signed [PROD_W-1:0]    p0_d, p1_d, p2_d, p0_q, p1_q, p2_q;
  logic [WGT_W-1:0]            wa, wb, wc;
  logic [2*WGT_W-1:0]          wxy_full, wxyz_full;
  logic [WGT_W-1:0]            wxy_q, wxyz_q;
  logic signed [DSUM_W-1:0]    dot_sum;
  logic signed [DOT_W-1:0]     dot_q;
  logic signed [TERM_W-1:0]    term_q;
  logic signed [OSUM_W-1:0]    sum_q;
  logic                        done_q;

  assign gx = $signed(grad_i[3*GRAD_W-1:2*GRAD_W]);
  assign gy = $signed(grad_i[2*GRAD_W-1:GRAD_W]);
  assign gz = $signed(grad_i[GRAD_W-1:0]);

  // The upper corner's offset f - 1 is the fraction with a set sign bit.
  assign offx = $signed({t1_q.a, frac_x_i});
  assign offy = $signed({t1_q.b, frac_y_i});
  assign offz = $signed({t1_q.c, frac_z_i});

  assign p0_d = gx * offx;
  assign p1_d = gy * offy;
  assign p2_d = gz * offz;

  assign wa        = t1_q.a ? wx_i.hi : wx_i.lo;
  assign wb        = t1_q.b ? wy_i.hi : wy_i.lo;
  assign wc        = t2_q.c ? wz_i.hi : wz_i.lo;
  assign wxy_full  = wa * wb;
  assign wxyz_full = wxy_q * wc;
  assign dot_sum   = DSUM_W'(p0_q) + DSUM_W'(p1_q) + DSUM_W'(p2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q   <= '0;
      t2_q   <= '0;
      t3_q   <= '0;
      t4_q   <= '0;
      done_q <= 1'b0;
    end else begin
      t1_q   <= tag_i;
      t2_q   <= t1_q;
      t3_q   <= t2_q;
      t4_q   <= t3_q;
      done_q <= t4_q.valid & t4_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q   <= p0_d;
    p1_q   <= p1_d;
    p2_q   <= p2_d;
    wxy_q  <= wxy_full[FRAC_BITS +: WGT_W];
    dot_q  <= dot_sum[DSUM_W-1:FRAC_BITS];
    wxyz_q <= wxyz_full[FRAC_BITS +: WGT_W];
    term_q <= dot_q * $signed({1'b0, wxyz_q});
    if (clear_i) begin
      sum_q <= '0;
    end else if (t4_q.valid) begin
      sum_q <= sum_q + OSUM_W'(term_q);
    end
  end

  assign osum_o = sum_q;
  assign done_o = done_q;

endmodule

// ===== verif/pgn_checker.sv =====
`timescale 1ns / 1ps

module pgn_checker import pgn_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [2:0]               kind_i,
  input  logic [7:0]               table_index_i,
  input  logic [PERM_W-1:0]        perm_value_i,
  input  logic signed [GRAD_W-1:0] grad_x_i,
  input  logic signed [GRAD_W-1:0] grad_y_i,
  input  logic signed [GRAD_W-1:0] grad_z_i,
  input  logic signed [POS_W-1:0]  pos_x_i,
  input  logic signed [POS_W-1:0]  pos_y_i,
  input  logic signed [POS_W-1:0]  pos_z_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [OUT_W-1:0]  noise_value_i,
  output int                       errors_o,
  output int                       pending_o
);

  localparam longint UNIT = longint'(1) << FRAC_BITS;

  logic signed [GRAD_W-1:0] grad_x_tab [256];
  logic signed [GRAD_W-1:0] grad_y_tab [256];
  logic signed [GRAD_W-1:0] grad_z_tab [256];
  logic [PERM_W-1:0]        perm_x_tab [256];
  logic [PERM_W-1:0]        perm_y_tab [256];
  logic [PERM_W-1:0]        perm_z_tab [256];
  logic [CFG_W-1:0]         octaves;
  logic                     turb_on;
  logic signed [OUT_W-1:0]  noise_q [$];

  function automatic longint hermite(input longint f);
    longint f2;
    f2 = (f * f) >> FRAC_BITS;
    return (f2 * (3 * UNIT - 2 * f)) >> FRAC_BITS;
  endfunction

  // One octave as a fixed-point sum with FRAC_BITS fraction bits, with the point scaled by 2^oct.
  function automatic longint octave_noise(input longint px, input longint py,
                                          input longint pz, input int oct);
    longint p [3];
    longint f [3];
    longint w [3][2];
    int     lat [3];
    longint s, dot, wxy, wxyz, acc;
    logic [7:0] h;
    p[0] = px; p[1] = py; p[2] = pz;
    acc = 0;
    for (int d = 0; d < 3; d++) begin
      s = p[d] << oct;
      lat[d] = int'((s >>> FRAC_BITS) & 255);
      f[d] = s & (UNIT - 1);
      w[d][1] = hermite(f[d]);
      w[d][0] = UNIT - w[d][1];
    end
    for (int a = 0; a < 2; a++) begin
      for (int b = 0; b < 2; b++) begin
        for (int c = 0; c < 2; c++) begin
          h = perm_x_tab[(lat[0] + a) & 255] ^ perm_y_tab[(lat[1] + b) & 255]
            ^ perm_z_tab[(lat[2] + c) & 255];
          dot = longint'(grad_x_tab[h]) * (f[0] - a * UNIT)
              + longint'(grad_y_tab[h]) * (f[1] - b * UNIT)
              + longint'(grad_z_tab[h]) * (f[2] - c * UNIT);
          wxy = (w[0][a] * w[1][b]) >> FRAC_BITS;
          wxyz = (wxy * w[2][c]) >> FRAC_BITS;
          acc += (dot >>> FRAC_BITS) * wxyz;
        end
      end
    end
    return acc;
  endfunction

  function automatic logic signed [OUT_W-1:0] noise_at(input longint px, input longint py,
                                                       input longint pz);
    longint acc, r;
    int     n;
    if (turb_on) begin
      n = (octaves > 8) ? 8 : int'(octaves);
      acc = 0;
      for (int o = 0; o < n; o++) acc += octave_noise(px, py, pz, o) >>> o;
      r = acc >>> FRAC_BITS;
      if (r < 0) r = -r;
    end else begin
      r = octave_noise(px, py, pz, 0) >>> FRAC_BITS;
    end
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[OUT_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
    pending_o = 0;
    octaves = 4'd7;
    turb_on = 1'b1;
  end

  always @(posedge clk_i) begin
    logic signed [OUT_W-1:0] want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_OCTAVE_COUNT) octaves = cfg_wdata_i;
        else turb_on = cfg_wdata_i[0];
      end
      if (in_valid_i && in_ready_i) begin
        case (kind_i)
          KIND_GRAD: begin
            grad_x_tab[table_index_i] = grad_x_i;
            grad_y_tab[table_index_i] = grad_y_i;
            grad_z_tab[table_index_i] = grad_z_i;
          end
          KIND_PERM_X: perm_x_tab[table_index_i] = perm_value_i;
          KIND_PERM_Y: perm_y_tab[table_index_i] = perm_value_i;
          KIND_PERM_Z: perm_z_tab[table_index_i] = perm_value_i;
          KIND_EVAL: noise_q.push_back(noise_at(longint'(pos_x_i), longint'(pos_y_i),
                                                longint'(pos_z_i)));
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (noise_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", noise_value_i));
        end else begin
          want = noise_q.pop_front();
          if (noise_value_i !== want)
            report_mismatch($sformatf("noise_value %0d, expected %0d", noise_value_i, want));
        end
      end
      pending_o = noise_q.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb import pgn_pkg::*; ();

  localparam logic [2:0] KIND_RSVD_FIRST = 3'd5;
  localparam logic [2:0] KIND_RSVD_LAST  = 3'd7;
  localparam int DRAIN_CYCLES = 400;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic                     cfg_index;
  logic [CFG_W-1:0]         cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  logic [2:0]               kind;
  logic [7:0]               table_index;
  logic [PERM_W-1:0]        perm_value;
  logic signed [GRAD_W-1:0] grad_x, grad_y, grad_z;
  logic signed [POS_W-1:0]  pos_x, pos_y, pos_z;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [OUT_W-1:0]  noise_value;
  int                       errors;
  int                       pending;
  logic                     calm;
  logic                     long_hold;

  perlin_gradient_noise_turbulence i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .kind_i(kind), .table_index_i(table_index), .perm_value_i(perm_value),
    .grad_x_i(grad_x), .grad_y_i(grad_y), .grad_z_i(grad_z),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .noise_value_o(noise_value)
  );

  pgn_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .kind_i(kind), .table_index_i(table_index), .perm_value_i(perm_value),
    .grad_x_i(grad_x), .grad_y_i(grad_y), .grad_z_i(grad_z),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .noise_value_i(noise_value),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic signed [GRAD_W-1:0] rand_grad();
    return GRAD_W'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  // Drives one transaction and returns at the edge where it is accepted.
  task automatic send(input logic [2:0] k, input logic [7:0] idx, input logic [7:0] pv,
                      input logic signed [GRAD_W-1:0] gx, input logic signed [GRAD_W-1:0] gy,
                      input logic signed [GRAD_W-1:0] gz, input logic signed [POS_W-1:0] px,
                      input logic signed [POS_W-1:0] py, input logic signed [POS_W-1:0] pz);
    in_valid <= 1'b1;
    kind <= k;
    table_index <= idx;
    perm_value <= pv;
    grad_x <= gx;
    grad_y <= gy;
    grad_z <= gz;
    pos_x <= px;
    pos_y <= py;
    pos_z <= pz;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_rand(input logic [2:0] k, input logic [7:0] idx);
    send(k, idx, 8'($urandom), rand_grad(), rand_grad(), rand_grad(),
         POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
  endtask

  task automatic eval_at(input logic signed [POS_W-1:0] px, input logic signed [POS_W-1:0] py,
                         input logic signed [POS_W-1:0] pz);
    send(KIND_EVAL, 8'($urandom), 8'($urandom), rand_grad(), rand_grad(), rand_grad(),
         px, py, pz);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Registers change only with nothing in flight; loads and ignored kinds give no
  // result, so the extra wait covers an evaluation that might still be running.
  task automatic write_cfg(input logic [CFG_W-1:0] oct, input logic turb);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_OCTAVE_COUNT;
    cfg_wdata <= oct;
    @(posedge clk);
    cfg_index <= REG_TURB_MODE;
    cfg_wdata <= CFG_W'(turb);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly evaluations, with table rewrites and ignored kinds mixed in.
  task automatic random_phase(input int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      maybe_gap();
      roll = $urandom_range(0, 9);
      if (roll < 7) begin
        if ($urandom_range(0, 3) == 0)
          eval_at(POS_W'($urandom_range(0, 32'h3_FFFF)), POS_W'($urandom_range(0, 32'h3_FFFF)),
                  POS_W'($urandom_range(0, 32'h3_FFFF)));
        else
          eval_at(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
      end else if (roll < 9) begin
        send_rand(3'($urandom_range(KIND_GRAD, KIND_PERM_Z)), 8'($urandom));
      end else begin
        send_rand(3'($urandom_range(KIND_RSVD_FIRST, KIND_RSVD_LAST)), 8'($urandom));
      end
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_OCTAVE_COUNT;
    cfg_wdata = '0;
    in_valid = 1'b0;
    kind = KIND_GRAD;
    table_index = '0;
    perm_value = '0;
    grad_x = '0;
    grad_y = '0;
    grad_z = '0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    calm = 1'b0;
    long_hold = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every table entry before any evaluation can read it.
    for (int i = 0; i < 256; i++) begin
      maybe_gap();
      if (i == 0)
        send(KIND_GRAD, 8'(i), 8'd0, -16'sd16384, 16'sd16384, 16'sd0, '0, '0, '0);
      else if (i == 255)
        send(KIND_GRAD, 8'(i), 8'd255, 16'sd16384, -16'sd16384, 16'sd16384, '1, '1, '1);
      else
        send_rand(KIND_GRAD, 8'(i));
      send(KIND_PERM_X, 8'(i), 8'($urandom), rand_grad(), rand_grad(), rand_grad(),
           '0, '0, '0);
      send(KIND_PERM_Y, 8'(i), 8'($urandom), rand_grad(), rand_grad(), rand_grad(),
           '0, '0, '0);
      send(KIND_PERM_Z, 8'(i), (i == 7) ? 8'd255 : 8'($urandom), rand_grad(), rand_grad(),
           rand_grad(), '0, '0, '0);
    end

    // Directed points: range ends, integer cell boundaries, fraction ends.
    eval_at(24'h000000, 24'h000000, 24'h000000);
    eval_at(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    eval_at(24'h800000, 24'h800000, 24'h800000);
    eval_at(24'hFFFFFF, 24'h00FFFF, 24'hFF0000);
    eval_at(24'h018000, 24'h7F8000, 24'h80FFFF);
    send_rand(KIND_RSVD_FIRST, 8'd3);
    send_rand(3'd6, 8'd4);
    send_rand(KIND_RSVD_LAST, 8'd5);
    write_cfg(4'd0, 1'b1);
    eval_at(24'h123456, 24'h800000, 24'h7FFFFF);
    write_cfg(4'd15, 1'b1);
    eval_at(24'h7FFFFF, 24'h800000, 24'h00FFFF);
    eval_at(24'h000001, 24'hFFFFFF, 24'h010000);
    write_cfg(4'd1, 1'b0);
    eval_at(24'h7FFFFF, 24'h800000, 24'hFFFFFF);
    eval_at(24'h008000, 24'h008000, 24'h008000);

    // The receiver holds off while evaluations keep coming, so the block backs up.
    write_cfg(4'd8, 1'b1);
    long_hold = 1'b1;
    random_phase(50);
    write_cfg(4'd1, 1'b1);
    random_phase(80);
    write_cfg(4'd3, 1'b0);
    random_phase(80);
    write_cfg(4'd12, 1'b1);
    random_phase(60);
    write_cfg(4'd0, 1'b1);
    random_phase(30);
    write_cfg(4'd5, 1'b1);
    random_phase(60);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    calm = 1'b1;
    write_cfg(4'd7, 1'b0);
    random_phase(40);
    write_cfg(4'd8, 1'b1);
    random_phase(40);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
